FILE: rtl/core/lapic_pkg.sv
// Shared types, codes and constants for the local APIC block.
package lapic_pkg;

    localparam int LVT_COUNT = 6;
    localparam int IO_PINS   = 24;
    localparam int REQ_WORDS = 8;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [31:0] LVT_MASK_BIT = 32'h0001_0000;
    localparam logic [31:0] LVT_PERIODIC = 32'h0002_0000;
    localparam logic [31:0] IO_VERSION   = 32'h0017_0011;
    localparam logic [31:0] IO_ID        = 32'h0200_0000;
    localparam logic [31:0] APIC_VERSION = 32'h0005_0010;
    localparam logic [31:0] IO_UNKNOWN   = 32'h0fff_ffff;
    localparam logic [31:0] LOC_UNKNOWN  = 32'hffff_ffff;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic exec;    // perform the captured item
        logic recon;   // run the timer reconfigure step
    } cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic need_recon;  // executed item asks for a reconfigure step
    } stat_t;

endpackage

FILE: rtl/core/lapic_ctrl.sv
// Controller state machine: sequences capture, execute, reconfigure, output.
module lapic_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  lapic_pkg::stat_t  stat,
    output lapic_pkg::cmd_t   cmd,
    output logic              s_ready,
    output logic              m_valid
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_RECON = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_EXEC;
            ST_EXEC:  state_next = stat.need_recon ? ST_RECON : ST_OUT;
            ST_RECON: state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign cmd.load  = in_fire;
    assign cmd.exec  = (state_reg == ST_EXEC);
    assign cmd.recon = (state_reg == ST_RECON);
endmodule

FILE: rtl/core/lapic_dp.sv
// Datapath: register file, request bitmap, timer and IOAPIC table.
module lapic_dp #(
    parameter int LVT_COUNT = lapic_pkg::LVT_COUNT,
    parameter int IO_PINS   = lapic_pkg::IO_PINS,
    parameter int REQ_WORDS = lapic_pkg::REQ_WORDS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lapic_pkg::cmd_t   cmd,
    output lapic_pkg::stat_t  stat,
    input  logic [7:0]        apic_id,
    input  logic [1:0]        req_type,
    input  logic              bar,
    input  logic [11:0]       offset,
    input  logic [31:0]       wdata,
    input  logic [7:0]        vector,
    output logic [31:0]       rdata,
    output logic              irq_valid,
    output logic [7:0]        irq_vector
);
    localparam int RT_DEPTH = 2 * IO_PINS;
    localparam int RT_AW    = $clog2(RT_DEPTH);
    localparam int LVT_AW   = $clog2(LVT_COUNT);
    localparam int REQ_BITS = 32 * REQ_WORDS;
    localparam int REQ_AW   = $clog2(REQ_BITS);

    // Captured item
    logic [1:0]  req_reg;
    logic        bar_reg;
    logic [11:0] off_reg;
    logic [31:0] wd_reg;
    logic [7:0]  vec_reg;

    logic [31:0] lvt_reg [LVT_COUNT];
    logic [31:0] redir_mem [RT_DEPTH];
    logic [RT_DEPTH-1:0] rt_wr_reg;
    logic [31:0] rt_rd_reg;
    logic [31:0] io_sel_reg, ldr_reg, dfr_reg, cinit_reg, cnow_reg, div_reg, freq_reg;
    logic [2:0]  dshift_reg;
    logic [63:0] tnow_reg, tref_reg, dead_reg;
    logic        armed_reg;
    logic [REQ_BITS-1:0] irr_reg;
    logic [31:0] rdata_reg;
    logic        irqv_reg;
    logic [7:0]  irqvec_reg;

    // Decode of the captured item
    logic        rt_hit;
    logic [RT_AW-1:0] rt_idx;
    logic [31:0] rt_val;
    logic        rt_we;
    logic        lvt_hit;
    logic [LVT_AW-1:0] lvt_idx;
    logic [63:0] tnext;
    logic        expire;
    logic        tick_irq;
    logic        recon_need;
    logic [31:0] cnow_upd;
    logic        irr_any;
    logic [REQ_AW-1:0] irr_low;
    logic [31:0] loc_rd, io_rd;
    logic [38:0] shifted;

    assign rt_hit  = (io_sel_reg >= 32'h10) && (io_sel_reg <= 32'h3f);
    assign rt_idx  = RT_AW'(io_sel_reg - 32'h10);
    assign lvt_hit = (off_reg >= 12'h320) && (off_reg <= 12'h370);
    assign lvt_idx = LVT_AW'((off_reg - 12'h320) >> 4);
    assign tnext   = tnow_reg + 64'd1;
    assign expire  = armed_reg && (tnext >= dead_reg);
    assign tick_irq = (req_reg == lapic_pkg::REQ_TICK) && expire;
    assign cnow_upd = cnow_reg - tnow_reg[31:0] + tref_reg[31:0];
    assign shifted = {7'd0, cnow_upd} << dshift_reg;

    // Timer deadline needs recomputing after this item
    assign recon_need = ((req_reg == lapic_pkg::REQ_WRITE) && !bar_reg
                         && (off_reg == 12'h320 || off_reg == 12'h380 || off_reg == 12'h390))
                        || (tick_irq && lvt_reg[0][17]);

    assign rt_we = cmd.exec && (req_reg == lapic_pkg::REQ_WRITE) && bar_reg
                   && (off_reg == 12'h010) && rt_hit;
    // Unwritten entries read as their reset value
    assign rt_val = rt_wr_reg[rt_idx] ? rt_rd_reg
                                      : (rt_idx[0] ? 32'd0 : lapic_pkg::LVT_MASK_BIT);

    // Redirection table: write the selected entry, register its read data
    always_ff @(posedge clk)
    begin
        if (rt_we)
            redir_mem[rt_idx] <= wd_reg;
        rt_rd_reg <= redir_mem[rt_idx];
    end

    // Lowest pending vector
    always_comb
    begin
        irr_any = 1'b0;
        irr_low = '0;
        for (int i = REQ_BITS - 1; i >= 0; i--)
        begin
            if (irr_reg[i])
            begin
                irr_any = 1'b1;
                irr_low = REQ_AW'(i);
            end
        end
    end

    // Read multiplexers
    always_comb
    begin
        io_rd = lapic_pkg::IO_UNKNOWN;
        if (off_reg == 12'h000)
            io_rd = io_sel_reg;
        else if (off_reg == 12'h010)
        begin
            if (io_sel_reg == 32'd0)      io_rd = lapic_pkg::IO_ID;
            else if (io_sel_reg == 32'd1) io_rd = lapic_pkg::IO_VERSION;
            else if (io_sel_reg == 32'd2) io_rd = 32'd0;
            else if (rt_hit)              io_rd = rt_val;
        end
    end

    always_comb
    begin
        loc_rd = lapic_pkg::LOC_UNKNOWN;
        if (off_reg == 12'h020)      loc_rd = {apic_id, 24'd0};
        else if (off_reg == 12'h030) loc_rd = lapic_pkg::APIC_VERSION;
        else if (off_reg == 12'h0d0) loc_rd = ldr_reg;
        else if (off_reg == 12'h0e0) loc_rd = dfr_reg;
        else if (off_reg >= 12'h100 && off_reg <= 12'h170) loc_rd = 32'd0;
        else if (off_reg >= 12'h200 && off_reg <= 12'h270) loc_rd = 32'd0;
        else if (off_reg == 12'h300) loc_rd = 32'd0;
        else if (lvt_hit)            loc_rd = lvt_reg[lvt_idx];
        else if (off_reg == 12'h380) loc_rd = cinit_reg;
        else if (off_reg == 12'h390) loc_rd = cnow_upd;
        else if (off_reg == 12'h3e0) loc_rd = div_reg;
        else if (off_reg == 12'h3f0) loc_rd = freq_reg;
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            bar_reg <= bar;
            off_reg <= offset;
            wd_reg  <= wdata;
            vec_reg <= vector;
        end
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LVT_COUNT; i++) lvt_reg[i] <= lapic_pkg::LVT_MASK_BIT;
            rt_wr_reg <= '0;
            io_sel_reg <= '0; ldr_reg <= '0; dfr_reg <= '0; cinit_reg <= '0;
            cnow_reg <= '0; div_reg <= '0; freq_reg <= '0; dshift_reg <= '0;
            tnow_reg <= '0; tref_reg <= '0; dead_reg <= '0; armed_reg <= 1'b0;
            irr_reg <= '0; rdata_reg <= '0; irqv_reg <= 1'b0; irqvec_reg <= '0;
        end
        else if (cmd.exec)
        begin
            rdata_reg  <= (req_reg == lapic_pkg::REQ_READ) ? (bar_reg ? io_rd : loc_rd)
                                                           : 32'd0;
            irqv_reg   <= tick_irq;
            irqvec_reg <= tick_irq ? lvt_reg[0][7:0] : 8'd0;
            case (req_reg)
                lapic_pkg::REQ_READ:
                begin
                    if (!bar_reg && off_reg == 12'h390)
                    begin
                        cnow_reg <= cnow_upd;
                        tref_reg <= tnow_reg;
                    end
                end
                lapic_pkg::REQ_WRITE:
                begin
                    if (bar_reg)
                    begin
                        if (off_reg == 12'h000) io_sel_reg <= wd_reg;
                        else if (off_reg == 12'h010 && rt_hit) rt_wr_reg[rt_idx] <= 1'b1;
                    end
                    else if (off_reg == 12'h0b0)
                    begin
                        if (!lvt_reg[4][16] && irr_any) irr_reg[irr_low] <= 1'b0;
                    end
                    else if (off_reg == 12'h0d0) ldr_reg <= wd_reg;
                    else if (off_reg == 12'h0e0) dfr_reg <= wd_reg;
                    else if (lvt_hit)
                        lvt_reg[lvt_idx] <= wd_reg;
                    else if (off_reg == 12'h380 || off_reg == 12'h390)
                    begin
                        if (off_reg == 12'h380) cinit_reg <= wd_reg;
                        cnow_reg  <= wd_reg;
                        tref_reg  <= tnow_reg;
                    end
                    else if (off_reg == 12'h3e0)
                    begin
                        div_reg    <= wd_reg;
                        dshift_reg <= {wd_reg[3], wd_reg[1:0]} + 3'd1;
                    end
                    else if (off_reg == 12'h3f0) freq_reg <= wd_reg;
                end
                lapic_pkg::REQ_SET:
                    irr_reg[vec_reg] <= 1'b1;
                default:
                begin
                    tnow_reg <= tnext;
                    if (expire)
                    begin
                        armed_reg <= 1'b0;
                        if (lvt_reg[0][17])
                        begin
                            cnow_reg <= cinit_reg;
                            tref_reg <= tnext;
                        end
                    end
                end
            endcase
        end
        else if (cmd.recon)
        begin
            // Unless the timer LVT is masked, bring the count up to date and set a new deadline
            if (!lvt_reg[0][16])
            begin
                cnow_reg  <= cnow_upd;
                tref_reg  <= tnow_reg;
                dead_reg  <= tnow_reg + {25'd0, shifted};
                armed_reg <= 1'b1;
            end
        end
    end

    assign stat.need_recon = recon_need;
    assign rdata      = rdata_reg;
    assign irq_valid  = irqv_reg;
    assign irq_vector = irqvec_reg;
endmodule

FILE: rtl/core/local_apic_with_ioapic_regs.sv
// Top level of the local APIC with IOAPIC window.
//  channel   | dir | handshake             | payload
//  s_axis    | in  | s_tvalid / s_tready   | req_type, bar, offset, wdata, vector
//  m_axis    | out | m_tvalid / m_tready   | rdata, irq_valid, irq_vector
//  apb       | in  | psel/penable/pwrite   | apic_id at address 0
// An item passes through capture, execute and output, with a reconfigure step
// before output when the timer deadline is recomputed; the output register holds until m_tready.
// Reset is asynchronous; the architectural state returns to its reset values at once.
// A stalled output blocks new transfers.
module local_apic_with_ioapic_regs #(
    parameter int LVT_COUNT = lapic_pkg::LVT_COUNT,
    parameter int IO_PINS   = lapic_pkg::IO_PINS,
    parameter int REQ_WORDS = lapic_pkg::REQ_WORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_type[1:0], bar, offset[11:0], wdata[31:0], vector[7:0], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // rdata[31:0], irq_valid, irq_vector[7:0], pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    lapic_pkg::cmd_t  cmd;
    lapic_pkg::stat_t stat;
    logic [7:0]  apic_id_reg;
    logic [31:0] rdata;
    logic        irq_valid;
    logic [7:0]  irq_vector;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            apic_id_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            apic_id_reg <= pwdata[7:0];
    end
    assign prdata = (paddr == 1'b0) ? {24'd0, apic_id_reg} : 32'd0;

    lapic_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
        .stat(stat), .cmd(cmd), .s_ready(s_tready), .m_valid(m_tvalid)
    );

    lapic_dp #(.LVT_COUNT(LVT_COUNT), .IO_PINS(IO_PINS), .REQ_WORDS(REQ_WORDS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .apic_id(apic_id_reg),
        .req_type(s_tdata[1:0]), .bar(s_tdata[2]), .offset(s_tdata[14:3]),
        .wdata(s_tdata[46:15]), .vector(s_tdata[54:47]),
        .rdata(rdata), .irq_valid(irq_valid), .irq_vector(irq_vector)
    );

    assign m_tdata = {7'd0, irq_vector, irq_valid, rdata};
endmodule

FILE: rtl/core/lapic_checker.sv
// Port-level checker for the local APIC block, bound to the top level.
module lapic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    // No new transfer while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while result pending");
    // The result is not yet valid in the execute state that follows an accepted transfer
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid ##1 1'b1)
        else $error("result too early");
    // Vector is zero without an interrupt
    a_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[32]) |-> (m_tdata[40:33] == 8'd0))
        else $error("vector without interrupt");
    // Held result stays stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed under stall");
endmodule

bind local_apic_with_ioapic_regs lapic_checker u_lapic_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: tb/local_apic_with_ioapic_regs_tb.sv
// Self-checking testbench for the local APIC with IOAPIC window: directed table, then random traffic.
`timescale 1ns / 100ps

module local_apic_with_ioapic_regs_tb;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 12;

    typedef struct packed {
        logic [7:0]  vector;
        logic [31:0] wdata;
        logic [11:0] offset;
        logic        bar;
        logic [1:0]  req;
    } apic_req_t;

    typedef struct packed {
        logic [7:0]  irq_vector;
        logic        irq_valid;
        logic [31:0] rdata;
    } apic_resp_t;

    typedef struct {
        apic_req_t   item;
        logic        fixed;
        logic [31:0] rdata;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // req_type[1:0], bar, offset[11:0], wdata[31:0], vector[7:0], pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // rdata[31:0], irq_valid, irq_vector[7:0], pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    local_apic_with_ioapic_regs dut (.*);

    always #5 clk = ~clk;

    // Model state of the APIC
    logic [7:0]   id_reg;
    logic [31:0]  lvt [lapic_pkg::LVT_COUNT];
    logic [31:0]  redir [2*lapic_pkg::IO_PINS];
    logic [31:0]  io_sel, ldr, dfr, cnt_init, cnt_now, div_word, freq;
    logic [2:0]   div_shift;
    logic [255:0] pending;
    logic [63:0]  t_now, t_ref, deadline;
    logic         armed;

    apic_resp_t   resp_q [$];
    table_row_t   dir_rows [$];
    int           mismatches = 0;
    int           sent = 0;
    int           received = 0;
    int           irqs_seen = 0;
    int           cycles = 0;
    logic         tx_burst = 1'b0;
    logic         rx_burst = 1'b0;

    // Clear the model state to its reset values
    function automatic void model_reset();
        id_reg = '0;
        foreach (lvt[i]) lvt[i] = lapic_pkg::LVT_MASK_BIT;
        foreach (redir[i]) redir[i] = (i % 2) ? 32'd0 : lapic_pkg::LVT_MASK_BIT;
        io_sel = '0; ldr = '0; dfr = '0; cnt_init = '0; cnt_now = '0;
        div_word = '0; freq = '0; div_shift = '0; pending = '0;
        t_now = '0; t_ref = '0; deadline = '0; armed = 1'b0;
    endfunction

    function automatic void catch_up_count();
        cnt_now = cnt_now - 32'(t_now - t_ref);
        t_ref = t_now;
    endfunction

    // Recompute the timer deadline; a masked timer keeps any old deadline
    function automatic void rearm_timer();
        if (!lvt[0][16]) begin
            catch_up_count();
            deadline = t_now + ({32'd0, cnt_now} << div_shift);
            armed = 1'b1;
        end
    endfunction

    function automatic logic [31:0] ioapic_read(logic [11:0] off);
        if (off == 12'h000) return io_sel;
        if (off == 12'h010) begin
            if (io_sel == 0) return lapic_pkg::IO_ID;
            if (io_sel == 1) return lapic_pkg::IO_VERSION;
            if (io_sel == 2) return 32'd0;
            if (io_sel >= 32'h10 && io_sel <= 32'h3f) return redir[io_sel - 32'h10];
        end
        return lapic_pkg::IO_UNKNOWN;
    endfunction

    function automatic logic [31:0] lapic_read(logic [11:0] off);
        if (off == 12'h020) return {id_reg, 24'd0};
        if (off == 12'h030) return lapic_pkg::APIC_VERSION;
        if (off == 12'h0d0) return ldr;
        if (off == 12'h0e0) return dfr;
        if (off >= 12'h100 && off <= 12'h170) return 32'd0;
        if (off >= 12'h200 && off <= 12'h270) return 32'd0;
        if (off == 12'h300) return 32'd0;
        if (off >= 12'h320 && off <= 12'h370) return lvt[(off - 12'h320) >> 4];
        if (off == 12'h380) return cnt_init;
        if (off == 12'h390) begin
            catch_up_count();
            return cnt_now;
        end
        if (off == 12'h3e0) return div_word;
        if (off == 12'h3f0) return freq;
        return lapic_pkg::LOC_UNKNOWN;
    endfunction

    function automatic void lapic_write(logic [11:0] off, logic [31:0] v);
        if (off == 12'h0b0) begin
            // EOI: drop the lowest pending vector unless LVT4 is masked
            if (!lvt[4][16])
                for (int b = 0; b < 256; b++)
                    if (pending[b]) begin
                        pending[b] = 1'b0;
                        break;
                    end
        end else if (off == 12'h0d0) ldr = v;
        else if (off == 12'h0e0) dfr = v;
        else if (off >= 12'h320 && off <= 12'h370) begin
            lvt[(off - 12'h320) >> 4] = v;
            if (off == 12'h320) rearm_timer();
        end else if (off == 12'h380) begin
            cnt_init = v; cnt_now = v; t_ref = t_now;
            rearm_timer();
        end else if (off == 12'h390) begin
            cnt_now = v; t_ref = t_now;
            rearm_timer();
        end else if (off == 12'h3e0) begin
            div_word = v;
            div_shift = 3'({v[3], v[1:0]} + 3'd1);
        end else if (off == 12'h3f0) freq = v;
    endfunction

    // Advance the model by one transfer and return the response it causes
    function automatic apic_resp_t apic_predict(apic_req_t it);
        apic_resp_t r;
        r = '0;
        case (it.req)
            lapic_pkg::REQ_READ:
                r.rdata = it.bar ? ioapic_read(it.offset) : lapic_read(it.offset);
            lapic_pkg::REQ_WRITE: begin
                if (it.bar) begin
                    if (it.offset == 12'h000) io_sel = it.wdata;
                    else if (it.offset == 12'h010 && io_sel >= 32'h10 && io_sel <= 32'h3f)
                        redir[io_sel - 32'h10] = it.wdata;
                end else
                    lapic_write(it.offset, it.wdata);
            end
            lapic_pkg::REQ_SET: pending[it.vector] = 1'b1;
            default: begin
                t_now = t_now + 64'd1;
                if (armed && t_now >= deadline) begin
                    armed = 1'b0;
                    r.irq_valid = 1'b1;
                    r.irq_vector = lvt[0][7:0];
                    if (lvt[0][17]) begin
                        cnt_now = cnt_init;
                        t_ref = t_now;
                        rearm_timer();
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap(ref logic burst);
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    // Drive one transfer; called and returns at a falling edge
    task automatic send_item(apic_req_t it, logic fixed, logic [31:0] fixed_rd);
        int gap;
        apic_resp_t r;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {1'b0, it};
        do @(posedge clk); while (!s_tready);
        r = apic_predict(it);
        if (fixed) r.rdata = fixed_rd;
        resp_q.push_back(r);
        sent++;
        @(negedge clk);
    endtask

    // Write the APIC ID over APB while the block is idle
    task automatic write_apic_id(logic [7:0] v);
        s_tvalid = 1'b0;
        wait (resp_q.size() == 0);
        repeat (SETTLE) @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = {24'd0, v};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        id_reg = v;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    function automatic logic [11:0] pick_offset();
        case ($urandom_range(0, 15))
            0: return 12'h020;
            1: return 12'h030;
            2: return 12'h0b0;
            3: return 12'h0d0;
            4: return 12'h0e0;
            5: return 12'h100 + 12'($urandom_range(0, 'h7f));
            6: return 12'h200 + 12'($urandom_range(0, 'h7f));
            7: return 12'h300;
            8, 9: return 12'h320 + 12'($urandom_range(0, 5) * 16);
            10, 11: return 12'h380;
            12: return 12'h390;
            13: return 12'h3e0;
            14: return 12'h3f0;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic apic_req_t random_item();
        apic_req_t it;
        int k;
        it.req = lapic_pkg::REQ_READ;
        it.bar = 1'b0;
        it.offset = 12'h000;
        it.wdata = $urandom;
        it.vector = 8'($urandom_range(0, 255));
        k = $urandom_range(0, 99);
        if (k < 30) it.req = lapic_pkg::REQ_TICK;
        else if (k < 45) it.req = lapic_pkg::REQ_SET;
        else it.req = (k < 72) ? lapic_pkg::REQ_WRITE : lapic_pkg::REQ_READ;
        if (it.req == lapic_pkg::REQ_WRITE || it.req == lapic_pkg::REQ_READ) begin
            if ($urandom_range(0, 4) == 0) begin
                it.bar = 1'b1;
                case ($urandom_range(0, 5))
                    0: it.offset = 12'($urandom_range(0, 4095));
                    1, 2: it.offset = 12'h000;
                    default: it.offset = 12'h010;
                endcase
                if (it.offset == 12'h000 && $urandom_range(0, 3) != 0)
                    it.wdata = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 2))
                                                           : 32'($urandom_range('h10, 'h3f));
            end else begin
                it.offset = pick_offset();
                // keep timer counts small so that expiries happen often
                if ((it.offset == 12'h380 || it.offset == 12'h390) && $urandom_range(0, 7) != 0)
                    it.wdata = 32'($urandom_range(0, 12));
                if (it.offset == 12'h320 && $urandom_range(0, 3) != 0)
                    it.wdata[16] = 1'b0;
                if (it.offset == 12'h3e0 && $urandom_range(0, 1) == 0)
                    it.wdata[3:0] = 4'b1011;
            end
        end
        return it;
    endfunction

    function automatic table_row_t row(logic [1:0] req, logic bar, logic [11:0] off,
                                       logic [31:0] wd, logic [7:0] vec,
                                       logic fixed, logic [31:0] rd);
        table_row_t t;
        t.item = '{vector: vec, wdata: wd, offset: off, bar: bar, req: req};
        t.fixed = fixed;
        t.rdata = rd;
        return t;
    endfunction

    // Check each response transfer against the oldest prediction
    initial begin
        int stall;
        apic_resp_t got, want;
        @(posedge rst_n);
        forever begin
            stall = draw_gap(rx_burst);
            repeat (stall) begin
                @(negedge clk);
                m_tready = 1'b0;
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got = apic_resp_t'(m_tdata[40:0]);
            received++;
            if (got.irq_valid) irqs_seen++;
            if (resp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
                want = resp_q.pop_front();
                if (got.rdata !== want.rdata || got.irq_valid !== want.irq_valid
                    || got.irq_vector !== want.irq_vector) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: rdata %h/%h irq %b/%b vector %h/%h (exp/act)",
                                 want.rdata, got.rdata, want.irq_valid, got.irq_valid,
                                 want.irq_vector, got.irq_vector);
                end
            end
        end
    end

    // Abort on a hang
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        model_reset();
        // directed table: fixed values only where obvious after reset
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h020, 0, 0, 1, 32'd0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h030, 0, 0, 1,
                               lapic_pkg::APIC_VERSION));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h010, 0, 0, 1,
                               lapic_pkg::LOC_UNKNOWN));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h16f, 0, 0, 1, 32'd0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h201, 0, 0, 1, 32'd0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h320, 0, 0, 1,
                               lapic_pkg::LVT_MASK_BIT));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h000, 0, 0, 1, 32'd0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h010, 0, 0, 1, lapic_pkg::IO_ID));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h004, 0, 0, 1,
                               lapic_pkg::IO_UNKNOWN));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 1, 12'h000, 32'd1, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h010, 0, 0, 1,
                               lapic_pkg::IO_VERSION));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 1, 12'h000, 32'h3f, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 1, 12'h010, 32'hffffffff, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h010, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 1, 12'h000, 32'h40, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 1, 12'h010, 0, 0, 1,
                               lapic_pkg::IO_UNKNOWN));
        dir_rows.push_back(row(lapic_pkg::REQ_SET, 0, 12'h000, 0, 8'd0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_SET, 0, 12'h000, 0, 8'd255, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h0b0, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h360, 32'd0, 0, 0, 0));
        for (int i = 0; i < 3; i++)
            dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h0b0, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h3e0, 32'hb, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h320, 32'h200ff, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h380, 32'd1, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_TICK, 0, 12'h000, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_TICK, 0, 12'h000, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h390, 0, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_WRITE, 0, 12'h3f0, 32'hffffffff, 0, 0, 0));
        dir_rows.push_back(row(lapic_pkg::REQ_READ, 0, 12'h3f0, 0, 0, 0, 0));

        // hold reset, then release it at a falling edge
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].rdata);

        // random traffic in phases, each after an APIC ID write: ff, then 00, then random values
        for (int ph = 0; ph < 4; ph++) begin
            write_apic_id((ph == 0) ? 8'hff : (ph == 1) ? 8'h00 : 8'($urandom_range(1, 254)));
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                send_item(random_item(), 1'b0, 32'd0);
                // let the response side drain completely once mid-phase
                if (ph == 2 && n == 40) begin
                    s_tvalid = 1'b0;
                    wait (resp_q.size() == 0);
                    @(negedge clk);
                end
            end
        end
        s_tvalid = 1'b0;

        wait (resp_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("%0d transfers sent, %0d responses checked, %0d timer interrupts seen",
                 sent, received, irqs_seen);
        $display("covered APIC and IOAPIC reads/writes, EOI, pending set, ticks, 4 APIC IDs");
        if (mismatches == 0 && resp_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
